>>> rtl/core/pcb_pkg.sv
// Shared constants, codes and types for the particle cell binning block.
// No dependencies; every other file but pcb_fifo refers to this package by scoped names.
package pcb_pkg;

  // Default structural sizes
  localparam int MAX_CELLS_DEF      = 4096;
  localparam int SLOTS_PER_CELL_DEF = 16;
  localparam int NUM_SPECIES_DEF    = 2;
  localparam int INDEX_BITS_DEF     = 16;

  // Fixed field widths
  localparam int CMD_W       = 2;
  localparam int PIDX_W      = 16;
  localparam int COORD_W     = 32;
  localparam int SCALE_W     = 32;
  localparam int CFG_CELLS_W = 13;
  localparam int STATUS_W    = 3;
  localparam int CELL_NUM_W  = 13;
  localparam int SLOT_NUM_W  = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 88;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 24;

  // Work queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BIN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SNAP  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_TOTAL   = 2'd2;

  // Register reset values
  localparam logic [SCALE_W-1:0]     INV_CELL_SIZE_RST = 32'd65536;
  localparam logic [CFG_CELLS_W-1:0] CELLS_PER_ROW_RST = 13'd64;
  localparam logic [CFG_CELLS_W-1:0] CELLS_TOTAL_RST   = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_INACTIVE = 3'd1,
    ST_BELOW    = 3'd2,
    ST_ABOVE    = 3'd3,
    ST_FULL     = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  // Work kinds handed from front to back
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_BIN    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SNAP   = 2'd3
  } op_t;

endpackage

>>> rtl/core/particle_cell_binning_top.sv
// Particle cell binning: bins 2D particles into square grid cells, clears and snapshots counts.
// Depends on pcb_pkg, pcb_front, pcb_fifo and pcb_back.
//
// After reset the block zeroes its count and snapshot memories, one entry per
// cycle, sweeping NUM_SPECIES * 2**ceil(log2(MAX_CELLS)) count entries (8192
// by default); in_tready stays low until that sweep ends, configuration writes
// are taken at any time. A bin command reads a cell count in S_IDLE and then,
// in S_UPD once the result register is free, writes it back with the slot
// entry unless the cell is full, so the back end takes no new particle until
// it is through with the last. Skipped, out-of-range and unused commands are
// reported straight from S_IDLE. Clear holds the back end while it walks the
// cell counts of one species one per cycle; snapshot walks the species-0
// counts the same way and waits for the last read to land before its done
// result. The front end registers items through its scale and row-term stages,
// and a four-entry queue lets it keep accepting while the back end is busy.
module particle_cell_binning_top #(
  parameter int MAX_CELLS      = pcb_pkg::MAX_CELLS_DEF,
  parameter int SLOTS_PER_CELL = pcb_pkg::SLOTS_PER_CELL_DEF,
  parameter int NUM_SPECIES    = pcb_pkg::NUM_SPECIES_DEF,
  parameter int INDEX_BITS     = pcb_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // particle_index[15:0], active[16], x_pos[48:17], z_pos[80:49], zero pad
  input  logic [pcb_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[1:0], species[2]
  input  logic [pcb_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cell_number[12:0], slot_number[17:13], zero pad
  output logic [pcb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[2:0]
  output logic [pcb_pkg::STATUS_W-1:0]      out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CELL_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SP_W    = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam int TOT_W   = ($clog2(MAX_CELLS + 1) > pcb_pkg::CFG_CELLS_W) ?
                           $clog2(MAX_CELLS + 1) : pcb_pkg::CFG_CELLS_W;
  localparam int ENTRY_W = 2 + pcb_pkg::STATUS_W + SP_W + CELL_W + INDEX_BITS;

  logic [pcb_pkg::SCALE_W-1:0]      inv_cell_size_r;
  logic [pcb_pkg::CFG_CELLS_W-1:0]  cells_per_row_r;
  logic [pcb_pkg::CFG_CELLS_W-1:0]  cells_total_r;
  logic [TOT_W-1:0]                 total_ext;
  logic [TOT_W-1:0]                 total_eff;
  logic                             init_busy;
  logic                             q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0]               q_wdata, q_rdata;
  logic [pcb_pkg::CELL_NUM_W-1:0]   cell_number;
  logic [pcb_pkg::SLOT_NUM_W-1:0]   slot_number;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_cell_size_r <= pcb_pkg::INV_CELL_SIZE_RST;
      cells_per_row_r <= pcb_pkg::CELLS_PER_ROW_RST;
      cells_total_r   <= pcb_pkg::CELLS_TOTAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcb_pkg::REG_INV_CELL_SIZE: inv_cell_size_r <= cfg_data[pcb_pkg::SCALE_W-1:0];
        pcb_pkg::REG_CELLS_PER_ROW: cells_per_row_r <= cfg_data[pcb_pkg::CFG_CELLS_W-1:0];
        pcb_pkg::REG_CELLS_TOTAL:   cells_total_r   <= cfg_data[pcb_pkg::CFG_CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // cells in use, capped at the table capacity
  assign total_ext = TOT_W'(cells_total_r);
  assign total_eff = (total_ext < TOT_W'(MAX_CELLS)) ? total_ext : TOT_W'(MAX_CELLS);

  pcb_front #(
    .MAX_CELLS   (MAX_CELLS),
    .NUM_SPECIES (NUM_SPECIES),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .cmd            (in_tuser[1:0]),
    .particle_index (in_tdata[15:0]),
    .active         (in_tdata[16]),
    .x_pos          (in_tdata[48:17]),
    .z_pos          (in_tdata[80:49]),
    .species        (in_tuser[2]),
    .inv_cell_size  (inv_cell_size_r),
    .cells_per_row  (cells_per_row_r),
    .total_eff      (total_eff),
    .init_busy      (init_busy),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  pcb_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (pcb_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  pcb_back #(
    .MAX_CELLS      (MAX_CELLS),
    .SLOTS_PER_CELL (SLOTS_PER_CELL),
    .NUM_SPECIES    (NUM_SPECIES),
    .INDEX_BITS     (INDEX_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .total_eff       (total_eff),
    .init_busy       (init_busy),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (out_tuser),
    .out_cell_number (cell_number),
    .out_slot_number (slot_number)
  );

  assign out_tdata = pcb_pkg::OUT_DATA_W'({slot_number, cell_number});

endmodule

>>> rtl/core/pcb_fifo.sv
// Small register queue carrying classified work from front to back.
// Uses no package items; width and depth come from the instantiating level.
module pcb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

>>> rtl/core/pcb_front.sv
// Front end: accepts items, scales coordinates to a linear cell and classifies.
// Depends on pcb_pkg for widths, command codes, status and work kinds.
module pcb_front #(
  parameter int MAX_CELLS   = pcb_pkg::MAX_CELLS_DEF,
  parameter int NUM_SPECIES = pcb_pkg::NUM_SPECIES_DEF,
  parameter int INDEX_BITS  = pcb_pkg::INDEX_BITS_DEF,
  localparam int CELL_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int SP_W    = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1,
  localparam int TOT_W   = ($clog2(MAX_CELLS + 1) > pcb_pkg::CFG_CELLS_W) ?
                           $clog2(MAX_CELLS + 1) : pcb_pkg::CFG_CELLS_W,
  localparam int ENTRY_W = 2 + pcb_pkg::STATUS_W + SP_W + CELL_W + INDEX_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pcb_pkg::CMD_W-1:0]        cmd,
  input  logic [pcb_pkg::PIDX_W-1:0]       particle_index,
  input  logic                             active,
  input  logic [pcb_pkg::COORD_W-1:0]      x_pos,
  input  logic [pcb_pkg::COORD_W-1:0]      z_pos,
  input  logic                             species,
  input  logic [pcb_pkg::SCALE_W-1:0]      inv_cell_size,
  input  logic [pcb_pkg::CFG_CELLS_W-1:0]  cells_per_row,
  input  logic [TOT_W-1:0]                 total_eff,
  input  logic                             init_busy,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [ENTRY_W-1:0]               q_wdata
);

  localparam int SUM_W = 48;

  // stage 1: magnitudes times scale
  logic                          s1_valid_r;
  logic [pcb_pkg::CMD_W-1:0]     s1_cmd_r;
  logic [INDEX_BITS-1:0]         s1_pidx_r;
  logic                          s1_act_r;
  logic [SP_W-1:0]               s1_sp_r;
  logic                          s1_xneg_r, s1_zneg_r;
  logic [31:0]                   s1_xq_r, s1_zq_r;

  // stage 2: signed column offset and row term
  logic                          s2_valid_r;
  logic [pcb_pkg::CMD_W-1:0]     s2_cmd_r;
  logic [INDEX_BITS-1:0]         s2_pidx_r;
  logic                          s2_act_r;
  logic [SP_W-1:0]               s2_sp_r;
  logic signed [32:0]            s2_col_r;
  logic signed [46:0]            s2_row_r;

  logic                          adv;
  logic                          x_neg, z_neg;
  logic [31:0]                   x_mag, z_mag;
  logic [63:0]                   x_prod, z_prod;
  logic                          sp_in;
  logic signed [32:0]            col_s, row_s;
  logic signed [13:0]            cpr_s;
  logic signed [46:0]            row_term;
  logic [SUM_W-1:0]              cell_m1;
  logic                          below, above;
  pcb_pkg::op_t                  op;
  pcb_pkg::status_t              status;

  assign adv      = !(s2_valid_r && q_full);
  assign in_ready = adv && !init_busy;
  assign q_push   = s2_valid_r && !q_full;

  // truncation toward zero: scale the magnitude, put the sign back later
  assign x_neg  = x_pos[pcb_pkg::COORD_W-1];
  assign z_neg  = z_pos[pcb_pkg::COORD_W-1];
  assign x_mag  = x_neg ? (~x_pos + 1'b1) : x_pos;
  assign z_mag  = z_neg ? (~z_pos + 1'b1) : z_pos;
  assign x_prod = {32'd0, x_mag} * {32'd0, inv_cell_size};
  assign z_prod = {32'd0, z_mag} * {32'd0, inv_cell_size};
  assign sp_in  = (NUM_SPECIES > 1) ? species : 1'b0;

  assign col_s    = s1_xneg_r ? -$signed({1'b0, s1_xq_r}) : $signed({1'b0, s1_xq_r});
  assign row_s    = s1_zneg_r ? -$signed({1'b0, s1_zq_r}) : $signed({1'b0, s1_zq_r});
  assign cpr_s    = $signed({1'b0, cells_per_row});
  assign row_term = row_s * cpr_s;

  // zero-based cell = col_q + row_q * cells_per_row
  assign cell_m1 = {s2_row_r[46], s2_row_r} + {{15{s2_col_r[32]}}, s2_col_r};
  assign below   = cell_m1[SUM_W-1];
  assign above   = !below && (cell_m1 >= SUM_W'(total_eff));

  always_comb begin
    op     = pcb_pkg::OP_REPORT;
    status = pcb_pkg::ST_DONE;
    case (s2_cmd_r)
      pcb_pkg::CMD_BIN: begin
        if (!s2_act_r)  status = pcb_pkg::ST_INACTIVE;
        else if (below) status = pcb_pkg::ST_BELOW;
        else if (above) status = pcb_pkg::ST_ABOVE;
        else            op     = pcb_pkg::OP_BIN;
      end
      pcb_pkg::CMD_CLEAR: op = pcb_pkg::OP_CLEAR;
      pcb_pkg::CMD_SNAP:  op = pcb_pkg::OP_SNAP;
      default:            op = pcb_pkg::OP_REPORT;
    endcase
  end

  assign q_wdata = {s2_pidx_r, cell_m1[CELL_W-1:0], s2_sp_r, status, op};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid && in_ready;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= cmd;
      s1_pidx_r <= INDEX_BITS'(particle_index);
      s1_act_r  <= active;
      s1_sp_r   <= SP_W'(sp_in);
      s1_xneg_r <= x_neg;
      s1_zneg_r <= z_neg;
      s1_xq_r   <= x_prod[63:32];
      s1_zq_r   <= z_prod[63:32];
      s2_cmd_r  <= s1_cmd_r;
      s2_pidx_r <= s1_pidx_r;
      s2_act_r  <= s1_act_r;
      s2_sp_r   <= s1_sp_r;
      s2_col_r  <= col_s;
      s2_row_r  <= row_term;
    end
  end

endmodule

>>> rtl/core/pcb_back.sv
// Back end: cell count, slot and snapshot memories, their sequencer and the
// result register. Depends on pcb_pkg for status codes and work kinds.
module pcb_back #(
  parameter int MAX_CELLS      = pcb_pkg::MAX_CELLS_DEF,
  parameter int SLOTS_PER_CELL = pcb_pkg::SLOTS_PER_CELL_DEF,
  parameter int NUM_SPECIES    = pcb_pkg::NUM_SPECIES_DEF,
  parameter int INDEX_BITS     = pcb_pkg::INDEX_BITS_DEF,
  localparam int CELL_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int SP_W    = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1,
  localparam int TOT_W   = ($clog2(MAX_CELLS + 1) > pcb_pkg::CFG_CELLS_W) ?
                           $clog2(MAX_CELLS + 1) : pcb_pkg::CFG_CELLS_W,
  localparam int ENTRY_W = 2 + pcb_pkg::STATUS_W + SP_W + CELL_W + INDEX_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  logic [ENTRY_W-1:0]                q_data,
  output logic                              q_pop,
  input  logic [TOT_W-1:0]                  total_eff,
  output logic                              init_busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcb_pkg::STATUS_W-1:0]      out_status,
  output logic [pcb_pkg::CELL_NUM_W-1:0]    out_cell_number,
  output logic [pcb_pkg::SLOT_NUM_W-1:0]    out_slot_number
);

  localparam int CNT_W     = $clog2(SLOTS_PER_CELL + 1);
  localparam int SLOT_AW   = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int CNT_AW    = SP_W + CELL_W;
  localparam int CNT_DEPTH = NUM_SPECIES << CELL_W;
  localparam int SNAP_DEPTH = 1 << CELL_W;
  localparam int SLOT_DEPTH = CNT_DEPTH << SLOT_AW;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_UPD, S_CLR, S_SNAP, S_FIN} state_t;

  logic [CNT_W-1:0]      cnt_mem  [CNT_DEPTH];
  logic [INDEX_BITS-1:0] slot_mem [SLOT_DEPTH];
  logic [CNT_W-1:0]      snap_mem [SNAP_DEPTH];

  state_t                         state_r, state_nxt;
  logic [CNT_AW-1:0]              init_addr_r, init_addr_nxt;
  logic [TOT_W-1:0]               walk_r, walk_nxt;
  logic [SP_W-1:0]                cur_sp_r, cur_sp_nxt;
  logic [CELL_W-1:0]              cur_cell_r, cur_cell_nxt;
  logic [INDEX_BITS-1:0]          cur_pidx_r, cur_pidx_nxt;
  logic                           snap_pend_r, snap_pend_nxt;
  logic [CELL_W-1:0]              snap_a_r, snap_a_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [pcb_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [pcb_pkg::CELL_NUM_W-1:0] out_cell_r, out_cell_nxt;
  logic [pcb_pkg::SLOT_NUM_W-1:0] out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]               rd_data_r;

  pcb_pkg::op_t                   q_op;
  pcb_pkg::status_t               q_status;
  logic [SP_W-1:0]                q_sp;
  logic [CELL_W-1:0]              q_cell;
  logic [INDEX_BITS-1:0]          q_pidx;

  logic                           out_free;
  logic [CNT_AW-1:0]              cur_addr, cnt_raddr, cnt_waddr;
  logic                           cnt_we;
  logic [CNT_W-1:0]               cnt_wdata;
  logic                           slot_we;
  logic                           snap_we;
  logic [CELL_W-1:0]              snap_waddr;
  logic [CNT_W-1:0]               snap_wdata;
  logic [CELL_W-1:0]              walk_cell;
  logic [pcb_pkg::CELL_NUM_W-1:0] cur_cell_num;

  assign q_op     = pcb_pkg::op_t'(q_data[1:0]);
  assign q_status = pcb_pkg::status_t'(q_data[2 +: pcb_pkg::STATUS_W]);
  assign q_sp     = q_data[2 + pcb_pkg::STATUS_W +: SP_W];
  assign q_cell   = q_data[2 + pcb_pkg::STATUS_W + SP_W +: CELL_W];
  assign q_pidx   = q_data[ENTRY_W-1 -: INDEX_BITS];

  assign out_free     = !out_valid_r || out_ready;
  assign cur_addr     = {cur_sp_r, cur_cell_r};
  assign walk_cell    = walk_r[CELL_W-1:0];
  assign cur_cell_num = pcb_pkg::CELL_NUM_W'({1'b0, cur_cell_r} + (CELL_W+1)'(1));

  assign init_busy       = (state_r == S_INIT);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_cell_number = out_cell_r;
  assign out_slot_number = out_slot_r;

  // snapshot reads land in the next cycle; the reset sweep also zeroes the copy
  assign snap_we    = snap_pend_r || (state_r == S_INIT);
  assign snap_waddr = (state_r == S_INIT) ? init_addr_r[CELL_W-1:0] : snap_a_r;
  assign snap_wdata = (state_r == S_INIT) ? '0 : rd_data_r;

  always_comb begin
    state_nxt      = state_r;
    init_addr_nxt  = init_addr_r;
    walk_nxt       = walk_r;
    cur_sp_nxt     = cur_sp_r;
    cur_cell_nxt   = cur_cell_r;
    cur_pidx_nxt   = cur_pidx_r;
    snap_pend_nxt  = 1'b0;
    snap_a_nxt     = snap_a_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_cell_nxt   = out_cell_r;
    out_slot_nxt   = out_slot_r;
    q_pop          = 1'b0;
    cnt_raddr      = cur_addr;
    cnt_we         = 1'b0;
    cnt_waddr      = cur_addr;
    cnt_wdata      = '0;
    slot_we        = 1'b0;

    case (state_r)
      S_INIT: begin
        cnt_we    = 1'b1;
        cnt_waddr = init_addr_r;
        if (init_addr_r == CNT_AW'(CNT_DEPTH - 1)) state_nxt = S_IDLE;
        else init_addr_nxt = init_addr_r + 1'b1;
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_op)
            pcb_pkg::OP_REPORT: begin
              if (out_free) begin
                q_pop          = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = q_status;
                out_cell_nxt   = '0;
                out_slot_nxt   = '0;
              end
            end
            pcb_pkg::OP_BIN: begin
              q_pop        = 1'b1;
              cur_sp_nxt   = q_sp;
              cur_cell_nxt = q_cell;
              cur_pidx_nxt = q_pidx;
              cnt_raddr    = {q_sp, q_cell};
              state_nxt    = S_UPD;
            end
            pcb_pkg::OP_CLEAR: begin
              q_pop      = 1'b1;
              cur_sp_nxt = q_sp;
              walk_nxt   = '0;
              state_nxt  = S_CLR;
            end
            pcb_pkg::OP_SNAP: begin
              q_pop     = 1'b1;
              walk_nxt  = '0;
              state_nxt = S_SNAP;
            end
            default: q_pop = 1'b0;
          endcase
        end
      end
      S_UPD: begin
        // count read is held on cur_addr until the result slot frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = cur_cell_num;
          if (rd_data_r >= CNT_W'(SLOTS_PER_CELL)) begin
            out_status_nxt = pcb_pkg::ST_FULL;
            out_slot_nxt   = '0;
          end else begin
            cnt_we         = 1'b1;
            cnt_wdata      = rd_data_r + 1'b1;
            slot_we        = 1'b1;
            out_status_nxt = pcb_pkg::ST_STORED;
            out_slot_nxt   = pcb_pkg::SLOT_NUM_W'(rd_data_r + 1'b1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        if (walk_r == total_eff) begin
          state_nxt = S_FIN;
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = {cur_sp_r, walk_cell};
          walk_nxt  = walk_r + 1'b1;
        end
      end
      S_SNAP: begin
        if (walk_r != total_eff) begin
          cnt_raddr     = {SP_W'(0), walk_cell};
          snap_pend_nxt = 1'b1;
          snap_a_nxt    = walk_cell;
          walk_nxt      = walk_r + 1'b1;
        end else if (!snap_pend_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pcb_pkg::ST_DONE;
          out_cell_nxt   = '0;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      snap_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      snap_pend_r <= snap_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    walk_r       <= walk_nxt;
    cur_sp_r     <= cur_sp_nxt;
    cur_cell_r   <= cur_cell_nxt;
    cur_pidx_r   <= cur_pidx_nxt;
    snap_a_r     <= snap_a_nxt;
    out_status_r <= out_status_nxt;
    out_cell_r   <= out_cell_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    rd_data_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[{cur_addr, rd_data_r[SLOT_AW-1:0]}] <= cur_pidx_r;
  end

  always_ff @(posedge clk) begin
    if (snap_we) snap_mem[snap_waddr] <= snap_wdata;
  end

endmodule
